// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the following edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/gpm_pkg.sv -----
// ----------------------------------------------------------------------------
// gpm_pkg
// Types and constants shared by the gamepad report mapper and its divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gpm_pkg;

	// Stream widths.
	localparam int unsigned S_TDATA_W = 112;
	localparam int unsigned M_TDATA_W = 80;

	// Field widths.
	localparam int unsigned BTN_W     = 10;
	localparam int unsigned DOWN_W    = 14;
	localparam int unsigned STICK_W   = 16;
	localparam int unsigned RAW_W     = 32;
	localparam int unsigned DIFF_W    = 33;
	localparam int unsigned ERR_W     = 35;
	localparam int unsigned MAG_W     = 34;
	localparam int unsigned ABSD_W    = 32;
	localparam int unsigned NUM_W     = 50;
	localparam int unsigned DEN_W     = 33;
	localparam int unsigned QUOT_W    = 15;
	localparam int unsigned DZ_W      = 15;
	localparam int unsigned BITS_W    = 6;
	localparam int unsigned STEP_W    = 4;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// Full scale in Q2.14.
	localparam logic [QUOT_W-1:0] Q_ONE = 15'd16384;

	// Register reset values.
	localparam logic [RAW_W-1:0]  AXIS_MIN_RST  = 32'd0;
	localparam logic [RAW_W-1:0]  AXIS_MAX_RST  = 32'd255;
	localparam logic [BITS_W-1:0] AXIS_BITS_RST = 6'd8;
	localparam logic [BITS_W-1:0] HAT_BITS_RST  = 6'd4;
	localparam logic [DZ_W-1:0]   DEADZONE_RST  = 15'd1966;

	typedef enum logic {
		OP_REPORT     = 1'b0,
		OP_DISCONNECT = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AXIS_MIN   = 3'd0,
		CFG_AXIS_MAX   = 3'd1,
		CFG_AXIS_BITS  = 3'd2,
		CFG_HAT_SIGNED = 3'd3,
		CFG_HAT_BITS   = 3'd4,
		CFG_DEADZONE   = 3'd5
	} cfg_index_t;

	// Request from the sequencer to the divider.
	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	// Status and result from the divider.
	typedef struct packed {
		logic              busy;
		logic              done;
		logic              sat;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

endpackage

// ----- rtl/gamepad_report_mapper.sv -----
// ----------------------------------------------------------------------------
// gamepad_report_mapper
// Maps parsed gamepad reports to button masks and a deadzoned Q2.14 stick.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Contents
// cfg       in         cfg_we               register index and write data
// s         in         s_tvalid / s_tready  one report or disconnect
// m         out        m_tvalid / m_tready  button masks and stick
//
// The input is not ready for the next item until the last one is through;
// a report runs each present axis in turn through the shared serial divider,
// unless the axis limits are equal. A disconnect never uses the divider.
// A report with no button field is dropped in the accepting cycle.
// The output register lets the next item enter while a result waits; the
// sequencer only stalls in its final cycle if that register is still full.
// Reset restores the register defaults and clears the held state.
//
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gamepad_report_mapper (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration writes.
	input  logic                              cfg_we,
	input  logic [gpm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gpm_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Input stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// button_usages, buttons_present, x_present, x_raw, y_present, y_raw,
	// hat_present, hat_raw, zero fill
	input  logic [gpm_pkg::S_TDATA_W-1:0]     s_tdata,
	// opcode
	input  logic [0:0]                        s_tuser,
	// Output stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// buttons_down, buttons_pressed, buttons_released, stick_x, stick_y,
	// zero fill
	output logic [gpm_pkg::M_TDATA_W-1:0]     m_tdata
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_HAT    = 11'b000_0000_0010,
		S_AXIS   = 11'b000_0000_0100,
		S_PREP_A = 11'b000_0000_1000,
		S_PREP_B = 11'b000_0001_0000,
		S_PREP_C = 11'b000_0010_0000,
		S_PREP_D = 11'b000_0100_0000,
		S_PREP_E = 11'b000_1000_0000,
		S_DIV    = 11'b001_0000_0000,
		S_ROUND  = 11'b010_0000_0000,
		S_FIN    = 11'b100_0000_0000
	} state_t;

	// Sign-extend a raw field by its configured width.
	function automatic logic [gpm_pkg::RAW_W-1:0] sign_ext(
		input logic [gpm_pkg::RAW_W-1:0]  raw,
		input logic                       ext,
		input logic [gpm_pkg::BITS_W-1:0] bits
	);
		logic [4:0]                sh;
		logic [gpm_pkg::RAW_W-1:0] up;
		sh = 5'(6'd32 - bits);
		up = raw << sh;
		if (!ext || (bits == '0) || (bits > 6'd32)) begin
			return raw;
		end
		return $unsigned($signed(up) >>> sh);
	endfunction

	// Zero a stick value whose magnitude is within the deadzone.
	function automatic logic [gpm_pkg::STICK_W-1:0] dead_zone(
		input logic [gpm_pkg::STICK_W-1:0] v,
		input logic [gpm_pkg::DZ_W-1:0]    dz
	);
		logic [gpm_pkg::STICK_W-1:0] mag;
		mag = v[gpm_pkg::STICK_W-1] ? (~v + 1'b1) : v;
		return (mag <= {1'b0, dz}) ? '0 : v;
	endfunction

	// Configuration registers.
	logic [gpm_pkg::RAW_W-1:0]   axis_min_q;
	logic [gpm_pkg::RAW_W-1:0]   axis_max_q;
	logic [gpm_pkg::BITS_W-1:0]  axis_bits_q;
	logic                        hat_signed_q;
	logic [gpm_pkg::BITS_W-1:0]  hat_bits_q;
	logic [gpm_pkg::DZ_W-1:0]    deadzone_q;

	// Captured input transaction.
	logic [gpm_pkg::BTN_W-1:0]   btn_q;
	logic                        x_present_q;
	logic [gpm_pkg::RAW_W-1:0]   x_raw_q;
	logic                        y_present_q;
	logic [gpm_pkg::RAW_W-1:0]   y_raw_q;
	logic                        hat_present_q;
	logic [gpm_pkg::RAW_W-1:0]   hat_raw_q;

	// Sequencer and working registers.
	state_t                      state_q;
	logic                        axis_y_q;
	logic                        disc_q;
	logic [gpm_pkg::DOWN_W-1:0]  down_q;
	logic [gpm_pkg::RAW_W-1:0]   val_q;
	logic [gpm_pkg::DIFF_W-1:0]  d_q;
	logic [gpm_pkg::DIFF_W-1:0]  diff_q;
	logic [gpm_pkg::ERR_W-1:0]   err_q;
	logic [gpm_pkg::ABSD_W-1:0]  absd_q;
	logic                        dzero_q;
	logic [gpm_pkg::MAG_W-1:0]   mag_q;
	logic                        neg_q;
	logic [gpm_pkg::STICK_W-1:0] sx_q;
	logic [gpm_pkg::STICK_W-1:0] sy_q;

	// Held state between reports.
	logic [gpm_pkg::DOWN_W-1:0]  held_btn_q;
	logic [gpm_pkg::STICK_W-1:0] held_sx_q;
	logic [gpm_pkg::STICK_W-1:0] held_sy_q;

	// Output register.
	logic                        ob_valid_q;
	logic [gpm_pkg::DOWN_W-1:0]  ob_down_q;
	logic [gpm_pkg::DOWN_W-1:0]  ob_pressed_q;
	logic [gpm_pkg::DOWN_W-1:0]  ob_released_q;
	logic [gpm_pkg::STICK_W-1:0] ob_sx_q;
	logic [gpm_pkg::STICK_W-1:0] ob_sy_q;

	// Combinational helpers.
	logic                        in_accept;
	logic [gpm_pkg::RAW_W-1:0]   cur_raw;
	logic                        cur_present;
	logic [gpm_pkg::RAW_W-1:0]   axis_ext;
	logic [gpm_pkg::RAW_W-1:0]   hat_val;
	logic                        hat_ok;
	logic [3:0]                  dpad;
	logic [gpm_pkg::DIFF_W-1:0]  d_neg;
	logic [gpm_pkg::ERR_W-1:0]   err_neg;
	logic [gpm_pkg::QUOT_W-1:0]  quot_clamp;
	logic [gpm_pkg::QUOT_W-1:0]  round_mag;
	logic                        round_neg;
	logic [gpm_pkg::STICK_W-1:0] mag_ext;
	logic [gpm_pkg::STICK_W-1:0] round_val;
	logic [gpm_pkg::DOWN_W-1:0]  fin_down;
	logic [gpm_pkg::STICK_W-1:0] fin_sx;
	logic [gpm_pkg::STICK_W-1:0] fin_sy;
	logic                        fin_ok;

	gpm_pkg::div_req_t           div_req;
	gpm_pkg::div_rsp_t           div_rsp;

	// Handshakes.
	assign s_tready  = (state_q == S_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign m_tvalid  = ob_valid_q;
	assign m_tdata   = {6'd0, ob_sy_q, ob_sx_q, ob_released_q, ob_pressed_q, ob_down_q};

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_min_q   <= gpm_pkg::AXIS_MIN_RST;
			axis_max_q   <= gpm_pkg::AXIS_MAX_RST;
			axis_bits_q  <= gpm_pkg::AXIS_BITS_RST;
			hat_signed_q <= 1'b0;
			hat_bits_q   <= gpm_pkg::HAT_BITS_RST;
			deadzone_q   <= gpm_pkg::DEADZONE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gpm_pkg::CFG_AXIS_MIN:   axis_min_q   <= cfg_data;
				gpm_pkg::CFG_AXIS_MAX:   axis_max_q   <= cfg_data;
				gpm_pkg::CFG_AXIS_BITS:  axis_bits_q  <= cfg_data[gpm_pkg::BITS_W-1:0];
				gpm_pkg::CFG_HAT_SIGNED: hat_signed_q <= cfg_data[0];
				gpm_pkg::CFG_HAT_BITS:   hat_bits_q   <= cfg_data[gpm_pkg::BITS_W-1:0];
				gpm_pkg::CFG_DEADZONE:   deadzone_q   <= cfg_data[gpm_pkg::DZ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Operand selection for the axis being worked on.
	assign cur_raw     = axis_y_q ? y_raw_q : x_raw_q;
	assign cur_present = axis_y_q ? y_present_q : x_present_q;
	assign axis_ext    = sign_ext(cur_raw, axis_min_q[gpm_pkg::RAW_W-1], axis_bits_q);

	// Hat decode: only directions 0 to 7 light the d-pad.
	assign hat_val = sign_ext(hat_raw_q, hat_signed_q, hat_bits_q);
	assign hat_ok  = hat_present_q && (hat_val[gpm_pkg::RAW_W-1:3] == '0);

	always_comb begin
		dpad = 4'b0000;
		if (hat_ok) begin
			unique case (hat_val[2:0])
				3'd0:    dpad = 4'b0001;
				3'd1:    dpad = 4'b0011;
				3'd2:    dpad = 4'b0010;
				3'd3:    dpad = 4'b0110;
				3'd4:    dpad = 4'b0100;
				3'd5:    dpad = 4'b1100;
				3'd6:    dpad = 4'b1000;
				default: dpad = 4'b1001;
			endcase
		end
	end

	// Negations used while preparing the division operands.
	assign d_neg   = ~d_q + 1'b1;
	assign err_neg = ~err_q + 1'b1;

	// Divider request: numerator |e| * 2^15 + |d|, denominator 2 * |d|.
	assign div_req.start = (state_q == S_PREP_E) && !dzero_q;
	assign div_req.num   = gpm_pkg::NUM_W'({mag_q, {gpm_pkg::QUOT_W{1'b0}}})
		+ gpm_pkg::NUM_W'(absd_q);
	assign div_req.den   = {absd_q, 1'b0};

	gpm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Clamp to full scale and apply the sign; Y is negated so up is positive.
	assign quot_clamp = (div_rsp.sat || (div_rsp.quot > gpm_pkg::Q_ONE))
		? gpm_pkg::Q_ONE : div_rsp.quot;
	assign round_mag  = dzero_q ? '0 : quot_clamp;
	assign round_neg  = neg_q ^ axis_y_q;
	assign mag_ext    = gpm_pkg::STICK_W'(round_mag);
	assign round_val  = round_neg ? (~mag_ext + 1'b1) : mag_ext;

	// Final result; a disconnect releases everything.
	assign fin_down = disc_q ? '0 : down_q;
	assign fin_sx   = disc_q ? '0 : dead_zone(sx_q, deadzone_q);
	assign fin_sy   = disc_q ? '0 : dead_zone(sy_q, deadzone_q);
	assign fin_ok   = (state_q == S_FIN) && (!ob_valid_q || m_tready);

	// Sequencer, held state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			axis_y_q   <= 1'b0;
			disc_q     <= 1'b0;
			ob_valid_q <= 1'b0;
			held_btn_q <= '0;
			held_sx_q  <= '0;
			held_sy_q  <= '0;
		end else begin
			if (fin_ok) begin
				ob_valid_q <= 1'b1;
				held_btn_q <= fin_down;
				held_sx_q  <= fin_sx;
				held_sy_q  <= fin_sy;
			end else if (m_tready) begin
				ob_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						axis_y_q <= 1'b0;
						if (s_tuser[0] == gpm_pkg::OP_DISCONNECT) begin
							disc_q  <= 1'b1;
							state_q <= S_FIN;
						end else begin
							disc_q <= 1'b0;
							if (s_tdata[10]) begin
								state_q <= S_HAT;
							end
						end
					end
				end
				S_HAT: state_q <= S_AXIS;
				S_AXIS: begin
					if (cur_present) begin
						state_q <= S_PREP_A;
					end else if (axis_y_q) begin
						state_q <= S_FIN;
					end else begin
						axis_y_q <= 1'b1;
					end
				end
				S_PREP_A: state_q <= S_PREP_B;
				S_PREP_B: state_q <= S_PREP_C;
				S_PREP_C: state_q <= S_PREP_D;
				S_PREP_D: state_q <= S_PREP_E;
				S_PREP_E: state_q <= dzero_q ? S_ROUND : S_DIV;
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					if (axis_y_q) begin
						state_q <= S_FIN;
					end else begin
						axis_y_q <= 1'b1;
						state_q  <= S_AXIS;
					end
				end
				S_FIN: begin
					if (fin_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			btn_q         <= s_tdata[9:0];
			x_present_q   <= s_tdata[11];
			x_raw_q       <= s_tdata[43:12];
			y_present_q   <= s_tdata[44];
			y_raw_q       <= s_tdata[76:45];
			hat_present_q <= s_tdata[77];
			hat_raw_q     <= s_tdata[109:78];
		end

		unique case (state_q)
			S_HAT: down_q <= {dpad, btn_q};
			S_AXIS: begin
				// An absent axis keeps the held value.
				if (!cur_present) begin
					if (axis_y_q) begin
						sy_q <= held_sy_q;
					end else begin
						sx_q <= held_sx_q;
					end
				end
			end
			S_PREP_A: begin
				val_q <= axis_ext;
				d_q   <= {axis_max_q[gpm_pkg::RAW_W-1], axis_max_q}
					- {axis_min_q[gpm_pkg::RAW_W-1], axis_min_q};
			end
			S_PREP_B: begin
				diff_q <= {val_q[gpm_pkg::RAW_W-1], val_q}
					- {axis_min_q[gpm_pkg::RAW_W-1], axis_min_q};
			end
			S_PREP_C: begin
				// e = 2 * (v - min) - d
				err_q   <= {diff_q[gpm_pkg::DIFF_W-1], diff_q, 1'b0}
					- {{2{d_q[gpm_pkg::DIFF_W-1]}}, d_q};
				absd_q  <= d_q[gpm_pkg::DIFF_W-1] ? d_neg[gpm_pkg::ABSD_W-1:0]
					: d_q[gpm_pkg::ABSD_W-1:0];
				dzero_q <= (d_q == '0);
			end
			S_PREP_D: begin
				mag_q <= err_q[gpm_pkg::ERR_W-1] ? err_neg[gpm_pkg::MAG_W-1:0]
					: err_q[gpm_pkg::MAG_W-1:0];
				neg_q <= err_q[gpm_pkg::ERR_W-1] ^ d_q[gpm_pkg::DIFF_W-1];
			end
			S_ROUND: begin
				if (axis_y_q) begin
					sy_q <= round_val;
				end else begin
					sx_q <= round_val;
				end
			end
			default: begin
			end
		endcase

		if (fin_ok) begin
			ob_down_q     <= fin_down;
			ob_pressed_q  <= fin_down & ~held_btn_q;
			ob_released_q <= held_btn_q & ~fin_down;
			ob_sx_q       <= fin_sx;
			ob_sy_q       <= fin_sy;
		end
	end

	// Checks.
	`ASSERT_IMPLIES(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
	`ASSERT_IMPLIES(a_div_done_in_div, div_rsp.done, state_q == S_DIV, "divider done outside wait")
	`ASSERT_IMPLIES(a_stick_range, m_tvalid, ($signed(ob_sx_q) >= -16'sd16384) && ($signed(ob_sx_q) <= 16'sd16384) && ($signed(ob_sy_q) >= -16'sd16384) && ($signed(ob_sy_q) <= 16'sd16384), "stick out of range")
	`ASSERT_IMPLIES(a_press_release, m_tvalid, (ob_pressed_q & ob_released_q) == '0, "button pressed and released at once")
	`ASSERT_NEXT(a_held_stable, !fin_ok, $stable(held_btn_q), "held buttons changed without a result")

endmodule

// ----- rtl/gpm_divider.sv -----
// ----------------------------------------------------------------------------
// gpm_divider
// Restoring divider, one quotient bit per cycle, flagging quotients of 2^15 or more.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpm_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  gpm_pkg::div_req_t  req,
	output gpm_pkg::div_rsp_t  rsp
);

	localparam logic [gpm_pkg::STEP_W-1:0] FIRST_STEP = gpm_pkg::STEP_W'(gpm_pkg::QUOT_W);

	logic                        busy_q;
	logic [gpm_pkg::STEP_W-1:0]  cnt_q;
	logic [gpm_pkg::NUM_W-1:0]   rem_q;
	logic [gpm_pkg::NUM_W-1:0]   dsh_q;
	logic [gpm_pkg::QUOT_W-1:0]  quot_q;
	logic                        sat_q;

	logic                        fits;
	logic [gpm_pkg::NUM_W-1:0]   rem_sub;

	// Shared compare and subtract against the shifted divisor.
	assign fits    = (rem_q >= dsh_q);
	assign rem_sub = rem_q - dsh_q;

	// Step counter: the first step only tests for overflow.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= FIRST_STEP;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Remainder, divisor and quotient datapath.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num;
			dsh_q  <= gpm_pkg::NUM_W'({req.den, {gpm_pkg::QUOT_W{1'b0}}});
			quot_q <= '0;
			sat_q  <= 1'b0;
		end else if (busy_q) begin
			if (cnt_q == FIRST_STEP) begin
				sat_q <= fits;
			end else begin
				quot_q <= {quot_q[gpm_pkg::QUOT_W-2:0], fits};
				if (fits) begin
					rem_q <= rem_sub;
				end
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = busy_q && (cnt_q == '0);
	assign rsp.sat  = sat_q;
	assign rsp.quot = quot_q;

endmodule

// ----- tb/gamepad_report_mapper_tb.sv -----
// ----------------------------------------------------------------------------
// gamepad_report_mapper_tb
// Self-checking testbench for the gamepad report mapper.
// ----------------------------------------------------------------------------
// Reports and disconnect events go in on the input stream, and each resulting
// button/stick transaction is compared against a behavioral model of the
// mapper kept inside this bench. A directed pass at the reset settings is
// followed by a sweep of register extremes and long randomized phases. Both
// stream sides idle in random bursts, except in every third and the last random phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gamepad_report_mapper_tb;

	localparam int SETTLE_CYCLES  = 60;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int MAX_SHOWN      = 10;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 225;

	// Hat switch directions, clockwise from up.
	typedef enum int {
		HAT_UP, HAT_UP_RIGHT, HAT_RIGHT, HAT_DOWN_RIGHT,
		HAT_DOWN, HAT_DOWN_LEFT, HAT_LEFT, HAT_UP_LEFT
	} hat_dir_t;

	localparam logic [gpm_pkg::DOWN_W-1:0] DPAD_UP    = 14'h0400;
	localparam logic [gpm_pkg::DOWN_W-1:0] DPAD_RIGHT = 14'h0800;
	localparam logic [gpm_pkg::DOWN_W-1:0] DPAD_DOWN  = 14'h1000;
	localparam logic [gpm_pkg::DOWN_W-1:0] DPAD_LEFT  = 14'h2000;

	typedef struct {
		gpm_pkg::opcode_t           op;
		logic [gpm_pkg::BTN_W-1:0]  usages;
		logic                       btn_pres;
		logic                       x_pres;
		logic [gpm_pkg::RAW_W-1:0]  x_raw;
		logic                       y_pres;
		logic [gpm_pkg::RAW_W-1:0]  y_raw;
		logic                       hat_pres;
		logic [gpm_pkg::RAW_W-1:0]  hat_raw;
	} report_t;

	// Laid out like m_tdata, lowest field last.
	typedef struct packed {
		logic [gpm_pkg::STICK_W-1:0] sy;
		logic [gpm_pkg::STICK_W-1:0] sx;
		logic [gpm_pkg::DOWN_W-1:0]  released;
		logic [gpm_pkg::DOWN_W-1:0]  pressed;
		logic [gpm_pkg::DOWN_W-1:0]  down;
	} mapped_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [gpm_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [gpm_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           s_tvalid;
	logic                           s_tready;
	// button_usages, buttons_present, x_present, x_raw, y_present, y_raw,
	// hat_present, hat_raw, zero fill
	logic [gpm_pkg::S_TDATA_W-1:0]  s_tdata;
	// opcode
	logic [0:0]                     s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	// buttons_down, buttons_pressed, buttons_released, stick_x, stick_y,
	// zero fill
	logic [gpm_pkg::M_TDATA_W-1:0]  m_tdata;

	// Model copy of the registers.
	longint                     axis_min  = 0;
	longint                     axis_max  = 255;
	logic [gpm_pkg::BITS_W-1:0] axis_bits = gpm_pkg::AXIS_BITS_RST;
	logic                       hat_sgn   = 1'b0;
	logic [gpm_pkg::BITS_W-1:0] hat_bits  = gpm_pkg::HAT_BITS_RST;
	longint                     dz        = 1966;

	// Model copy of the held state.
	logic [gpm_pkg::DOWN_W-1:0] held_btn = '0;
	longint                     held_x   = 0;
	longint                     held_y   = 0;

	mapped_t expected_maps[$];
	bit      idle_en = 1'b1;
	int      mismatches = 0;
	int      reports_sent = 0;
	int      disconnects_sent = 0;
	int      reports_dropped = 0;
	int      results_checked = 0;
	int      reg_writes = 0;
	int      quiet_cycles = 0;

	gamepad_report_mapper u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Mapper model
	// ------------------------------------------------------------------

	// Sign-extends a raw field of the given width, or reads all 32 bits
	// as two's complement when extension is off or the width is unusable.
	function automatic longint raw_to_int(logic [gpm_pkg::RAW_W-1:0] raw, logic extend,
			logic [gpm_pkg::BITS_W-1:0] bits);
		longint m;
		longint v;
		if (!extend || bits == 0 || bits > 32)
			return longint'($signed(raw));
		m = longint'(1) << bits;
		v = longint'(raw) & (m - 1);
		if ((v & (m >> 1)) != 0)
			v = v - m;
		return v;
	endfunction

	// Scales a logical axis value to Q2.14, rounding half away from zero.
	function automatic longint axis_to_q14(longint v);
		longint d;
		longint n;
		longint an;
		longint ad;
		longint q;
		bit     neg;
		d = axis_max - axis_min;
		if (d == 0)
			return 0;
		n = (2 * (v - axis_min) - d) * 16384;
		neg = (n < 0) != (d < 0);
		an = (n < 0) ? -n : n;
		ad = (d < 0) ? -d : d;
		q = (2 * an + ad) / (2 * ad);
		if (q > 16384)
			q = 16384;
		return neg ? -q : q;
	endfunction

	function automatic longint deadzoned(longint v);
		longint m;
		m = (v < 0) ? -v : v;
		return (m <= dz) ? 0 : v;
	endfunction

	// Works out the result of one accepted item and advances the held state.
	// Returns 0 when the item causes no result.
	function automatic bit map_report(input report_t r, output mapped_t o);
		longint                     sx;
		longint                     sy;
		longint                     hv;
		logic [gpm_pkg::DOWN_W-1:0] down;
		o = '0;
		if (r.op == gpm_pkg::OP_DISCONNECT) begin
			o.released = held_btn;
			held_btn = '0;
			held_x = 0;
			held_y = 0;
			return 1'b1;
		end
		if (!r.btn_pres)
			return 1'b0;

		sx = held_x;
		sy = held_y;
		if (r.x_pres)
			sx = axis_to_q14(raw_to_int(r.x_raw, axis_min < 0, axis_bits));
		if (r.y_pres)
			sy = -axis_to_q14(raw_to_int(r.y_raw, axis_min < 0, axis_bits));

		// Hat to d-pad; negative or out-of-range values stay neutral.
		down = {4'b0, r.usages};
		if (r.hat_pres) begin
			hv = raw_to_int(r.hat_raw, hat_sgn, hat_bits);
			if (hv == HAT_UP || hv == HAT_UP_RIGHT || hv == HAT_UP_LEFT)
				down |= DPAD_UP;
			if (hv == HAT_UP_RIGHT || hv == HAT_RIGHT || hv == HAT_DOWN_RIGHT)
				down |= DPAD_RIGHT;
			if (hv == HAT_DOWN_RIGHT || hv == HAT_DOWN || hv == HAT_DOWN_LEFT)
				down |= DPAD_DOWN;
			if (hv == HAT_DOWN_LEFT || hv == HAT_LEFT || hv == HAT_UP_LEFT)
				down |= DPAD_LEFT;
		end

		sx = deadzoned(sx);
		sy = deadzoned(sy);
		o.down = down;
		o.pressed = down & ~held_btn;
		o.released = held_btn & ~down;
		o.sx = sx[gpm_pkg::STICK_W-1:0];
		o.sy = sy[gpm_pkg::STICK_W-1:0];
		held_btn = down;
		held_x = sx;
		held_y = sy;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Item construction
	// ------------------------------------------------------------------

	function automatic report_t mk_report(logic [gpm_pkg::BTN_W-1:0] usages, logic xp,
			logic [gpm_pkg::RAW_W-1:0] x, logic yp, logic [gpm_pkg::RAW_W-1:0] y, logic hp,
			logic [gpm_pkg::RAW_W-1:0] hat);
		report_t r;
		r.op = gpm_pkg::OP_REPORT;
		r.usages = usages;
		r.btn_pres = 1'b1;
		r.x_pres = xp;
		r.x_raw = x;
		r.y_pres = yp;
		r.y_raw = y;
		r.hat_pres = hp;
		r.hat_raw = hat;
		return r;
	endfunction

	// Mostly values inside the logical range, some just outside, some noise.
	function automatic logic [gpm_pkg::RAW_W-1:0] pick_axis_raw();
		longint      lo;
		longint      hi;
		longint      v;
		logic [63:0] r;
		int          sel;
		lo = (axis_min < axis_max) ? axis_min : axis_max;
		hi = (axis_min < axis_max) ? axis_max : axis_min;
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			r = {$urandom, $urandom};
			v = lo + longint'(r % (hi - lo + 1));
		end else if (sel < 85) begin
			v = (sel % 2 == 0) ? lo - longint'($urandom_range(0, 3))
				: hi + longint'($urandom_range(0, 3));
		end else begin
			v = longint'($urandom);
		end
		return v[gpm_pkg::RAW_W-1:0];
	endfunction

	function automatic logic [gpm_pkg::RAW_W-1:0] pick_hat_raw();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return $urandom_range(HAT_UP, HAT_UP_LEFT);
		else if (sel < 75)
			return $urandom_range(8, 15);
		else if (sel < 85)
			return '1;
		return $urandom;
	endfunction

	function automatic report_t rand_report();
		report_t r;
		r.op = ($urandom_range(0, 29) == 0) ? gpm_pkg::OP_DISCONNECT : gpm_pkg::OP_REPORT;
		r.usages = gpm_pkg::BTN_W'($urandom_range(0, 1023));
		r.btn_pres = ($urandom_range(0, 9) != 0);
		r.x_pres = ($urandom_range(0, 5) != 0);
		r.x_raw = pick_axis_raw();
		r.y_pres = ($urandom_range(0, 5) != 0);
		r.y_raw = pick_axis_raw();
		r.hat_pres = ($urandom_range(0, 5) != 0);
		r.hat_raw = pick_hat_raw();
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Sends one item, records its expected result at the accepting edge.
	// Entered and left just after a falling edge.
	task automatic drive_report(input report_t r);
		mapped_t m;
		int      gap;
		if (idle_en && $urandom_range(0, 7) == 0) begin
			s_tvalid = 1'b0;
			gap = $urandom_range(1, 9);
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = r.op;
		s_tdata = {2'b0, r.hat_raw, r.hat_pres, r.y_raw, r.y_pres, r.x_raw,
			r.x_pres, r.btn_pres, r.usages};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (map_report(r, m))
			expected_maps.push_back(m);
		else
			reports_dropped++;
		if (r.op == gpm_pkg::OP_DISCONNECT)
			disconnects_sent++;
		else
			reports_sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			drive_report(rand_report());
	endtask

	// Waits for every expected result, then for the block to go quiet.
	task automatic settle_idle();
		while (expected_maps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input gpm_pkg::cfg_index_t idx,
			input logic [gpm_pkg::CFG_DATA_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		reg_writes++;
		case (idx)
			gpm_pkg::CFG_AXIS_MIN:   axis_min = longint'($signed(val));
			gpm_pkg::CFG_AXIS_MAX:   axis_max = longint'($signed(val));
			gpm_pkg::CFG_AXIS_BITS:  axis_bits = val[gpm_pkg::BITS_W-1:0];
			gpm_pkg::CFG_HAT_SIGNED: hat_sgn = val[0];
			gpm_pkg::CFG_HAT_BITS:   hat_bits = val[gpm_pkg::BITS_W-1:0];
			gpm_pkg::CFG_DEADZONE:   dz = longint'(val[gpm_pkg::DZ_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic apply_config(input longint lmin, input longint lmax, input int abits,
			input bit hsgn, input int hbits, input int dzone);
		settle_idle();
		write_reg(gpm_pkg::CFG_AXIS_MIN, lmin[31:0]);
		write_reg(gpm_pkg::CFG_AXIS_MAX, lmax[31:0]);
		write_reg(gpm_pkg::CFG_AXIS_BITS, abits);
		write_reg(gpm_pkg::CFG_HAT_SIGNED, gpm_pkg::CFG_DATA_W'(hsgn));
		write_reg(gpm_pkg::CFG_HAT_BITS, hbits);
		write_reg(gpm_pkg::CFG_DEADZONE, dzone);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset settings: every hat direction, neutral hats, absent axes,
	// the deadzone edge, a dropped report and disconnects.
	task automatic test_reset_settings();
		report_t r;
		drive_report(mk_report(10'h3FF, 1, 0, 1, 255, 1, HAT_UP));
		drive_report(mk_report(10'h000, 1, 255, 1, 0, 1, HAT_UP_RIGHT));
		drive_report(mk_report(10'h155, 1, 128, 1, 127, 1, HAT_RIGHT));
		drive_report(mk_report(10'h2AA, 1, 142, 1, 143, 1, HAT_DOWN_RIGHT));
		drive_report(mk_report(10'h001, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FF00, 1, HAT_DOWN));
		drive_report(mk_report(10'h002, 0, 0, 1, 64, 1, HAT_DOWN_LEFT));
		drive_report(mk_report(10'h004, 1, 200, 0, 0, 1, HAT_LEFT));
		drive_report(mk_report(10'h008, 0, 0, 0, 0, 1, HAT_UP_LEFT));
		drive_report(mk_report(10'h3F0, 1, 10, 1, 250, 1, 8));
		drive_report(mk_report(10'h00F, 1, 250, 1, 10, 1, 15));
		drive_report(mk_report(10'h200, 1, 0, 1, 0, 1, 32'hFFFF_FFFF));
		drive_report(mk_report(10'h100, 1, 255, 1, 255, 0, HAT_UP));
		// A report with no button field is dropped.
		r = mk_report(10'h3FF, 1, 0, 1, 0, 1, HAT_UP);
		r.btn_pres = 1'b0;
		drive_report(r);
		r = mk_report(10'h3FF, 1, 0, 1, 0, 1, HAT_UP);
		r.op = gpm_pkg::OP_DISCONNECT;
		drive_report(r);
		drive_report(r);
		drive_report(mk_report(10'h021, 0, 0, 0, 0, 1, HAT_UP));
		// Disconnect ignores everything else in the item.
		r = mk_report(10'h3FF, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
		r.op = gpm_pkg::OP_DISCONNECT;
		r.btn_pres = 1'b0;
		drive_report(r);
	endtask

	// Register extremes: widest and narrowest fields, equal and reversed
	// limits, no deadzone and a full-scale deadzone, signed hats.
	task automatic extremes_run();
		drive_report(mk_report(10'h3FF, 1, 32'h0, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF));
		drive_report(mk_report(10'h155, 1, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1, 32'h8000_0000));
		drive_report(mk_report(10'h0AA, 1, 32'h7FFF_FFFF, 1, 32'h8000_0000, 1, 32'h7FFF_FFFF));
		send_random(20);
	endtask

	task automatic test_register_extremes();
		apply_config(-64'sd2147483648, 64'sd2147483647, 32, 1, 32, 0);
		extremes_run();
		apply_config(100, 100, 8, 0, 4, 16384);
		extremes_run();
		apply_config(100, -100, 8, 1, 3, 500);
		extremes_run();
		apply_config(-100, 100, 8, 1, 3, 500);
		extremes_run();
		apply_config(-1, 0, 1, 1, 1, 0);
		extremes_run();
		apply_config(0, 1023, 10, 0, 3, 16384);
		extremes_run();
		apply_config(64'sd2147483647, -64'sd2147483648, 32, 0, 32, 1);
		extremes_run();
	endtask

	// Random phases, each under a fresh register setting. One phase in
	// three runs without idling, and the last phase has none at all.
	task automatic test_random_traffic();
		int     abits;
		int     hbits;
		longint lmin;
		longint lmax;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			abits = $urandom_range(1, 32);
			hbits = ($urandom_range(0, 1) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 32);
			case ($urandom_range(0, 3))
				0: begin
					lmin = -(longint'(1) << (abits - 1));
					lmax = (longint'(1) << (abits - 1)) - 1;
				end
				1: begin
					lmin = 0;
					lmax = (longint'(1) << abits) - 1;
				end
				2: begin
					lmin = longint'($signed($urandom));
					lmax = longint'($signed($urandom));
				end
				default: begin
					lmin = longint'($urandom_range(0, 200)) - 100;
					lmax = ($urandom_range(0, 1) == 0) ? lmin : -lmin;
				end
			endcase
			apply_config(lmin, lmax, abits, 1'($urandom_range(0, 1)), hbits,
				($urandom_range(0, 7) == 0) ? 16384 : $urandom_range(0, 4000));
			idle_en = (p % 3 != 2) && (p != RANDOM_PHASES - 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Hold off the sender until the output side has caught up.
				if (i == PHASE_ITEMS / 2) begin
					while (expected_maps.size() != 0)
						@(posedge clk);
					@(negedge clk);
				end
				drive_report(rand_report());
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------

	// Receiver back-pressure in random bursts.
	initial begin : stall_output
		int stall_len;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_en && $urandom_range(0, 7) == 0) begin
				m_tready = 1'b0;
				stall_len = $urandom_range(1, 9);
				repeat (stall_len) @(negedge clk);
			end
			m_tready = 1'b1;
		end
	end

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin : check_results
		mapped_t want;
		mapped_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(mapped_t)-1:0];
			results_checked++;
			if (expected_maps.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("%0t: unexpected result down=%h pressed=%h released=%h x=%0d y=%0d",
						$realtime, got.down, got.pressed, got.released,
						$signed(got.sx), $signed(got.sy));
			end else begin
				want = expected_maps.pop_front();
				if (got.down !== want.down || got.pressed !== want.pressed ||
						got.released !== want.released || got.sx !== want.sx ||
						got.sy !== want.sy) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN) begin
						$display("%0t: mismatch: expected down=%h pressed=%h released=%h x=%0d y=%0d",
							$realtime, want.down, want.pressed, want.released,
							$signed(want.sx), $signed(want.sy));
						$display("%0t:           actual down=%h pressed=%h released=%h x=%0d y=%0d",
							$realtime, got.down, got.pressed, got.released,
							$signed(got.sx), $signed(got.sy));
					end
				end
			end
		end
	end

	// Ends the run when no transaction moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired after %0d quiet cycles, %0d results outstanding",
				quiet_cycles, expected_maps.size());
			$display("gamepad_report_mapper test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = gpm_pkg::OP_REPORT;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_settings();
		test_register_extremes();
		test_random_traffic();

		// Drain, then give stray results a chance to show up.
		while (expected_maps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d reports and %0d disconnects (%0d dropped), %0d register writes.",
			reports_sent, disconnects_sent, reports_dropped, reg_writes);
		$display("Checked %0d results, %0d mismatched.", results_checked, mismatches);
		if (mismatches == 0 && expected_maps.size() == 0)
			$display("gamepad_report_mapper test passed");
		else
			$display("gamepad_report_mapper test failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/gpm_pkg.sv
rtl/gpm_divider.sv
rtl/gamepad_report_mapper.sv
tb/gamepad_report_mapper_tb.sv
